// ===== rtl/glos_pkg.sv =====
// shared constants, command type and helpers for the grid line-of-sight unit
package glos_pkg;

    // map geometry, border included
    localparam int MAP_ROWS = 64;
    localparam int MAP_COLS = 64;

    // interior bitmap: one memory row per interior map row, one bit per interior column
    localparam int ROW_CNT = MAP_ROWS - 2;
    localparam int COL_CNT = MAP_COLS - 2;
    localparam int ROW_AW  = $clog2(ROW_CNT);
    localparam int COL_W   = $clog2(COL_CNT);

    localparam int COORD_W = 8;
    localparam int ERR_W   = COORD_W + 2;

    // stream widths
    localparam int IN_W   = 40;
    localparam int USER_W = 2;
    localparam int OUT_W  = 8;

    // short command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [COORD_W-1:0] X_MAX = COORD_W'(MAP_ROWS - 2);
    localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(MAP_COLS - 2);

    // action codes on the input stream
    localparam logic [USER_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [USER_W-1:0] ACT_READ  = 2'd1;
    localparam logic [USER_W-1:0] ACT_LOS   = 2'd2;
    localparam logic [USER_W-1:0] ACT_NONE  = 2'd3;

    // command kinds after classification
    localparam logic [2:0] KIND_NONE  = 3'd0;  // answer 0, no bitmap access
    localparam logic [2:0] KIND_WALL  = 3'd1;  // answer 1, no bitmap access
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_LOS   = 3'd4;

    typedef struct packed {
        logic [2:0]                kind;
        logic [COORD_W-1:0]        x0;
        logic [COORD_W-1:0]        y0;
        logic [COORD_W-1:0]        x1;
        logic [COORD_W-1:0]        y1;
        logic                      wv;
        logic [COORD_W-1:0]        dx;
        logic [COORD_W-1:0]        dy;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [ERR_W-1:0]   err0;
    } cmd_t;

    // true for an interior cell
    function automatic logic cell_inside(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y);
        return (x >= COORD_W'(1)) && (x <= X_MAX) && (y >= COORD_W'(1)) && (y <= Y_MAX);
    endfunction

    // memory row of an interior cell
    function automatic logic [ROW_AW-1:0] row_of(input logic [COORD_W-1:0] x);
        logic [COORD_W-1:0] t;
        t = x - COORD_W'(1);
        return t[ROW_AW-1:0];
    endfunction

    // bit within the row of an interior cell
    function automatic logic [COL_W-1:0] col_of(input logic [COORD_W-1:0] y);
        logic [COORD_W-1:0] t;
        t = y - COORD_W'(1);
        return t[COL_W-1:0];
    endfunction

endpackage

// ===== rtl/glos_ram.sv =====
// generic single-write, single-read ram with registered read data
module glos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/glos_fifo.sv =====
// two-entry command queue between front and back
module glos_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  glos_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output glos_pkg::cmd_t head,
    output logic           empty
);
    import glos_pkg::*;

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("command queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("command popped from empty queue");

endmodule

// ===== rtl/glos_front.sv =====
// front end: accepts input transfers and classifies them into commands
module glos_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [glos_pkg::IN_W-1:0]   s_tdata,
    input  logic [glos_pkg::USER_W-1:0] s_tuser,
    input  logic                        q_full,
    output logic                        q_push,
    output glos_pkg::cmd_t              q_cmd
);
    import glos_pkg::*;

    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               wv;
    logic               start_in;
    logic               same_pt;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;

    // field unpack
    assign x0 = s_tdata[7:0];
    assign y0 = s_tdata[15:8];
    assign x1 = s_tdata[23:16];
    assign y1 = s_tdata[31:24];
    assign wv = s_tdata[32];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign start_in = cell_inside(x0, y0);
    assign same_pt  = (x0 == x1) && (y0 == y1);
    assign dx       = (x1 > x0) ? x1 - x0 : x0 - x1;
    assign dy       = (y1 > y0) ? y1 - y0 : y0 - y1;

    // classification and walk setup
    always_comb
    begin
        q_cmd.x0    = x0;
        q_cmd.y0    = y0;
        q_cmd.x1    = x1;
        q_cmd.y1    = y1;
        q_cmd.wv    = wv;
        q_cmd.dx    = dx;
        q_cmd.dy    = dy;
        q_cmd.neg_x = !(x0 < x1);
        q_cmd.neg_y = !(y0 < y1);
        q_cmd.err0  = (dx > dy) ? $signed({2'b00, 1'b0, dx[COORD_W-1:1]})
                                : -$signed({2'b00, 1'b0, dy[COORD_W-1:1]});
        unique case (s_tuser)
            ACT_WRITE: q_cmd.kind = start_in ? KIND_WRITE : KIND_NONE;
            ACT_READ:  q_cmd.kind = start_in ? KIND_READ : KIND_WALL;
            ACT_LOS:   q_cmd.kind = same_pt ? KIND_NONE : (start_in ? KIND_LOS : KIND_WALL);
            ACT_NONE:  q_cmd.kind = KIND_NONE;
            default:   q_cmd.kind = KIND_NONE;
        endcase
    end

endmodule

// ===== rtl/glos_back.sv =====
// back end: bitmap access, line walk and the output register
module glos_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  glos_pkg::cmd_t             q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [glos_pkg::OUT_W-1:0] m_tdata
);
    import glos_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WMOD = 3'd1;
    localparam logic [2:0] S_RCHK = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [COORD_W-1:0]      cur_x_reg;
    logic [COORD_W-1:0]      cur_x_next;
    logic [COORD_W-1:0]      cur_y_reg;
    logic [COORD_W-1:0]      cur_y_next;
    logic [COORD_W-1:0]      end_x_reg;
    logic [COORD_W-1:0]      end_y_reg;
    logic [COORD_W-1:0]      dx_reg;
    logic [COORD_W-1:0]      dy_reg;
    logic                    neg_x_reg;
    logic                    neg_y_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic                    wv_reg;
    logic                    load_cmd;
    logic                    chk_vld_reg;
    logic                    chk_vld_next;
    logic [COL_W-1:0]        chk_col_reg;
    logic [COL_W-1:0]        chk_col_next;
    logic                    rowv_reg;
    logic                    res_reg;
    logic                    res_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_bit_reg;
    logic                    out_load;
    logic [ROW_CNT-1:0]      row_valid_reg;
    logic [ROW_CNT-1:0]      row_valid_next;

    logic                    rd_en;
    logic [ROW_AW-1:0]       rd_addr;
    logic [COL_CNT-1:0]      rd_data;
    logic                    wr_en;
    logic [ROW_AW-1:0]       wr_row;
    logic [COL_CNT-1:0]      wr_data;

    logic                    cell_bit;
    logic                    hit;
    logic signed [ERR_W-1:0] dx_s;
    logic signed [ERR_W-1:0] dy_s;
    logic                    step_x;
    logic                    step_y;

    // wall bitmap, one row per interior map row
    glos_ram #(
        .WIDTH (COL_CNT),
        .DEPTH (ROW_CNT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_row),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a row never written reads as floor
    assign cell_bit = rowv_reg && rd_data[chk_col_reg];
    assign hit      = chk_vld_reg && cell_bit;

    // bresenham step decision
    assign dx_s   = $signed({2'b00, dx_reg});
    assign dy_s   = $signed({2'b00, dy_reg});
    assign step_x = (err_reg > -dx_s);
    assign step_y = (err_reg < dy_s);

    // read-modify-write row for a cell write
    assign wr_row = row_of(cur_x_reg);
    always_comb
    begin
        wr_data = rowv_reg ? rd_data : '0;
        wr_data[chk_col_reg] = !wv_reg;
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_bit_reg);

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        chk_vld_next   = chk_vld_reg;
        chk_col_next   = chk_col_reg;
        res_next       = res_reg;
        row_valid_next = row_valid_reg;
        load_cmd       = 1'b0;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = row_of(cur_x_reg);
        wr_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    load_cmd   = 1'b1;
                    cur_x_next = q_head.x0;
                    cur_y_next = q_head.y0;
                    err_next   = q_head.err0;
                    rd_addr    = row_of(q_head.x0);
                    unique case (q_head.kind)
                        KIND_WRITE:
                        begin
                            rd_en        = 1'b1;
                            chk_col_next = col_of(q_head.y0);
                            state_next   = S_WMOD;
                        end
                        KIND_READ:
                        begin
                            rd_en        = 1'b1;
                            chk_col_next = col_of(q_head.y0);
                            chk_vld_next = 1'b1;
                            state_next   = S_RCHK;
                        end
                        KIND_LOS:
                        begin
                            state_next = S_WALK;
                        end
                        KIND_WALL:
                        begin
                            res_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            res_next   = 1'b0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_WMOD:
            begin
                wr_en                  = 1'b1;
                row_valid_next[wr_row] = 1'b1;
                res_next               = 1'b0;
                state_next             = S_OUT;
            end
            S_RCHK:
            begin
                res_next     = cell_bit;
                chk_vld_next = 1'b0;
                state_next   = S_OUT;
            end
            S_WALK:
            begin
                // one cell read issued per cycle, checked on the next
                priority if (hit)
                begin
                    res_next     = 1'b1;
                    chk_vld_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if ((cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg))
                begin
                    res_next     = 1'b0;
                    chk_vld_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if (!cell_inside(cur_x_reg, cur_y_reg))
                begin
                    res_next     = 1'b1;
                    chk_vld_next = 1'b0;
                    state_next   = S_OUT;
                end
                else
                begin
                    rd_en        = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_col_next = col_of(cur_y_reg);
                    err_next     = err_reg - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
                    if (step_x)
                    begin
                        cur_x_next = neg_x_reg ? cur_x_reg - COORD_W'(1)
                                               : cur_x_reg + COORD_W'(1);
                    end
                    if (step_y)
                    begin
                        cur_y_next = neg_y_reg ? cur_y_reg - COORD_W'(1)
                                               : cur_y_reg + COORD_W'(1);
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register holds one result while the back end moves on
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        err_reg     <= err_next;
        chk_col_reg <= chk_col_next;
        res_reg     <= res_next;
        if (load_cmd)
        begin
            end_x_reg <= q_head.x1;
            end_y_reg <= q_head.y1;
            dx_reg    <= q_head.dx;
            dy_reg    <= q_head.dy;
            neg_x_reg <= q_head.neg_x;
            neg_y_reg <= q_head.neg_y;
            wv_reg    <= q_head.wv;
        end
        if (rd_en)
        begin
            rowv_reg <= row_valid_reg[rd_addr];
        end
        if (out_load)
        begin
            out_bit_reg <= res_reg;
        end
    end

    // checks
    a_chk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_WALK || state_reg == S_RCHK))
        else $error("pending cell check outside read or walk");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result shown without sequencer hand-off");

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> row_valid_reg[$past(wr_row)])
        else $error("written bitmap row not marked valid");

endmodule

// ===== rtl/grid_line_of_sight_unit.sv =====
// top level of the grid line-of-sight unit
//
// Wall bitmap of the 62 x 62 map interior (one bit per cell, floor after reset,
// border and outside cells always wall) with three operations selected by
// s_tuser: 0 writes a cell (write_value 0 makes wall, 1 makes floor), 1 reads
// a cell (blocked = 1 for wall), 2 walks a Bresenham line from start toward end,
// end excluded, and answers blocked = 1 if any visited cell is a wall; code 3
// answers 0. Every input transfer yields exactly one output transfer, in order.
// A front end classifies transfers into a two-entry command queue, so input
// keeps flowing while the back end works, until the queue is full. Outside-cell
// reads and writes, code 3 and start-equals-end queries skip the bitmap; a
// write does a read-modify-write of a bitmap row; a query walks one cell per
// cycle through the single bitmap read port, checking each cell it reads.
// No clearing pass is needed after reset: each bitmap row has a valid flag.
module grid_line_of_sight_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24],
    // write_value[32], zero[39:33]
    input  logic [glos_pkg::IN_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [glos_pkg::USER_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // blocked[0], zero[7:1]
    output logic [glos_pkg::OUT_W-1:0]  m_tdata
);
    import glos_pkg::*;

    cmd_t q_in;
    cmd_t q_head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // input side
    glos_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    // command queue
    glos_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // execution and output side
    glos_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/tb_grid_line_of_sight_unit.sv =====
// testbench for the grid line-of-sight unit: wall bitmap writes, reads and line queries
module tb_grid_line_of_sight_unit;

    import glos_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int PHASE_COUNT    = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int STEP_GUARD     = 1024;

    // bitmap shadow and in-order store of predicted answers
    class los_scoreboard;
        bit wall_map [MAP_ROWS][MAP_COLS];
        bit predicted_blocked [$];
        int errors;
        int transfers_in;
        int transfers_out;
        int queries_blocked;
        int queries_clear;

        // border and outside cells are always wall
        function bit wall_at(int x, int y);
            if (x < 1 || x > MAP_ROWS - 2 || y < 1 || y > MAP_COLS - 2)
                return 1'b1;
            return wall_map[x][y];
        endfunction

        // bresenham walk, end cell excluded
        function bit line_hits_wall(int x0, int y0, int x1, int y1);
            int dx;
            int dy;
            int sx;
            int sy;
            int err;
            int e2;
            int steps;
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = (dx > dy) ? dx / 2 : -(dy / 2);
            for (steps = 0; steps < STEP_GUARD; steps++)
            begin
                if (x0 == x1 && y0 == y1)
                    return 1'b0;
                if (wall_at(x0, y0))
                    return 1'b1;
                e2 = err;
                if (e2 > -dx)
                begin
                    err -= dy;
                    x0 += sx;
                end
                if (e2 < dy)
                begin
                    err += dx;
                    y0 += sy;
                end
            end
            return 1'b0;
        endfunction

        // apply an accepted input transfer and queue its answer
        function void note_input(logic [USER_W-1:0] action, logic [IN_W-1:0] data);
            int sx;
            int sy;
            int ex;
            int ey;
            bit wv;
            bit answer;
            sx = data[7:0];
            sy = data[15:8];
            ex = data[23:16];
            ey = data[31:24];
            wv = data[32];
            answer = 1'b0;
            transfers_in++;
            case (action)
                ACT_WRITE:
                begin
                    if (sx >= 1 && sx <= MAP_ROWS - 2 && sy >= 1 && sy <= MAP_COLS - 2)
                        wall_map[sx][sy] = !wv;
                end
                ACT_READ:
                    answer = wall_at(sx, sy);
                ACT_LOS:
                begin
                    answer = line_hits_wall(sx, sy, ex, ey);
                    if (answer)
                        queries_blocked++;
                    else
                        queries_clear++;
                end
                default:
                    answer = 1'b0;
            endcase
            predicted_blocked.push_back(answer);
        endfunction

        // compare an accepted output transfer with the oldest prediction
        function void check_result(logic [OUT_W-1:0] data);
            bit want;
            transfers_out++;
            if (predicted_blocked.size() == 0)
            begin
                $error("unexpected output transfer, tdata %0h", data);
                errors++;
                return;
            end
            want = predicted_blocked.pop_front();
            if (data[0] !== want)
            begin
                $error("blocked mismatch: expected %0d, actual %0d", want, data[0]);
                errors++;
            end
            if (data[OUT_W-1:1] !== '0)
            begin
                $error("pad mismatch: expected 0, actual %0h", data[OUT_W-1:1]);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_blocked.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [USER_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    los_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_request;

    grid_line_of_sight_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitor both sides
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0 && !hold_taken)
            begin
                hold_left = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one item and wait for its transfer
    task automatic send_item(logic [USER_W-1:0] action, int sx, int sy, int ex, int ey,
                             bit wv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {7'b0, wv, ey[7:0], ex[7:0], sy[7:0], sx[7:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // mostly interior, some border, some anywhere in the byte range
    function automatic int pick_coord(int interior_max);
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, interior_max);
        else if (r < 90)
            return ($urandom_range(1) != 0) ? interior_max + 1 : 0;
        return $urandom_range(255);
    endfunction

    // one random item with weighted action mix
    task automatic send_random_item();
        int r;
        int sx;
        int sy;
        int ex;
        int ey;
        bit wv;
        r  = $urandom_range(99);
        sx = pick_coord(MAP_ROWS - 2);
        sy = pick_coord(MAP_COLS - 2);
        wv = ($urandom_range(99) >= 25);
        if ($urandom_range(99) < 60)
        begin
            // short lines near the start point
            ex = (sx + $urandom_range(0, 24) - 12) & 8'hff;
            ey = (sy + $urandom_range(0, 24) - 12) & 8'hff;
        end
        else
        begin
            ex = pick_coord(MAP_ROWS - 2);
            ey = pick_coord(MAP_COLS - 2);
        end
        if (r < 35)
            send_item(ACT_WRITE, sx, sy, ex, ey, wv);
        else if (r < 60)
            send_item(ACT_READ, sx, sy, ex, ey, wv);
        else if (r < 95)
            send_item(ACT_LOS, sx, sy, ex, ey, wv);
        else
            send_item(ACT_NONE, sx, sy, ex, ey, wv);
    endtask

    // main sequence
    initial
    begin
        int phase;
        int n;
        sb = new();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_NONE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, border, start equals end, long walks, unused code
        send_item(ACT_READ,  0,   0,   0,   0,   1'b0);
        send_item(ACT_READ,  1,   1,   0,   0,   1'b0);
        send_item(ACT_READ,  62,  62,  0,   0,   1'b0);
        send_item(ACT_READ,  63,  63,  0,   0,   1'b0);
        send_item(ACT_READ,  255, 255, 255, 255, 1'b1);
        send_item(ACT_WRITE, 1,   1,   0,   0,   1'b0);
        send_item(ACT_READ,  1,   1,   0,   0,   1'b0);
        send_item(ACT_WRITE, 62,  62,  0,   0,   1'b0);
        send_item(ACT_WRITE, 0,   5,   0,   0,   1'b0);
        send_item(ACT_READ,  0,   5,   0,   0,   1'b0);
        send_item(ACT_WRITE, 255, 255, 255, 255, 1'b1);
        send_item(ACT_LOS,   1,   1,   1,   1,   1'b0);
        send_item(ACT_LOS,   0,   0,   0,   0,   1'b0);
        send_item(ACT_LOS,   2,   2,   62,  62,  1'b0);
        send_item(ACT_LOS,   1,   1,   10,  10,  1'b0);
        send_item(ACT_LOS,   5,   5,   255, 170, 1'b0);
        send_item(ACT_LOS,   255, 255, 0,   0,   1'b0);
        send_item(ACT_NONE,  255, 255, 255, 255, 1'b1);
        send_item(ACT_WRITE, 62,  62,  0,   0,   1'b1);
        send_item(ACT_LOS,   62,  1,   1,   62,  1'b0);
        send_item(ACT_READ,  62,  62,  0,   0,   1'b0);
        send_item(ACT_WRITE, 1,   1,   0,   0,   1'b1);
        send_item(ACT_LOS,   1,   62,  62,  40,  1'b0);
        send_item(ACT_LOS,   30,  3,   31,  60,  1'b0);

        // random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 81;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 81;
                end
                default:
                begin
                    tx_idle_pct = 28;
                    rx_stall_pct = 28;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++)
            begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 0 && n == 20)
                    hold_request = HOLD_CYCLES;
                send_random_item();
            end
        end

        // drain
        s_tvalid <= 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items, checked %0d answers; line queries: %0d blocked, %0d clear",
                 sb.transfers_in, sb.transfers_out, sb.queries_blocked, sb.queries_clear);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
